// File: hw/rtl/vpcs_pkg.sv
// shared types, constants and helpers for the cosine similarity block
`default_nettype none
package vpcs_pkg;

    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 48;
    localparam int SIM_W     = 16;
    localparam int ROOT_W    = 24;
    localparam int NUM_W     = 64;
    localparam int QUOT_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int CFG_W     = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [QUOT_W-1:0] SIM_ONE = QUOT_W'(16384);
    localparam logic REG_MIN_DENOM = 1'b0;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     last;
        logic signed [SUM_W-1:0]  dot;
        logic signed [SUM_W-1:0]  norm_a;
        logic signed [SUM_W-1:0]  norm_b;
    } vpcs_entry_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [PROD_W-1:0] x
    );
        logic signed [SUM_W:0] r;
        r = (SUM_W+1)'(s) + (SUM_W+1)'(x);
        if (r[SUM_W] != r[SUM_W-1])
            sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_add = r[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vector_product_cosine_similarity.sv
// top level of the streaming cosine similarity block
// The front end takes one element pair per cycle and passes it to a four-beat
// queue; the back end returns one result beat per cycle while out_stall is low
// for pairs that do not end a vector. A last pair holds the back end while it
// loads the sums, runs 24 two-bit square root steps, one multiply, one range
// check and 16 restoring divide steps (skipped when the floor or saturation
// settles the result) and then loads the output register.
// The front end keeps taking beats until the queue fills.
`default_nettype none
module vector_product_cosine_similarity (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [vpcs_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [vpcs_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                               last_elem,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [vpcs_pkg::PROD_W-1:0]      product,
    output logic signed [vpcs_pkg::SIM_W-1:0]       similarity,
    output logic                                    similarity_valid,
    output logic                                    last_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import vpcs_pkg::*;

    logic              push, pop, q_empty, q_full;
    vpcs_entry_t       push_entry, head;
    logic [CFG_W-1:0]  min_den_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DENOM) ? 32'(min_den_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_den_reg <= CFG_W'(1);
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DENOM)
            min_den_reg <= pwdata[CFG_W-1:0];
    end

    vpcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .last_elem  (last_elem),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    vpcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    vpcs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (q_empty),
        .pop              (pop),
        .min_denominator  (min_den_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .product          (product),
        .similarity       (similarity),
        .similarity_valid (similarity_valid),
        .last_out         (last_out)
    );

    a_valid_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> similarity_valid == last_out)
        else $error("similarity_valid differs from last_out");

    a_zero_when_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !similarity_valid |-> similarity == '0)
        else $error("similarity nonzero on a non-final beat");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && similarity_valid |->
            (similarity <= 16'sd16384 && similarity >= -16'sd16384))
        else $error("similarity outside unit range");

endmodule
`default_nettype wire

// File: hw/rtl/vpcs_front.sv
// front end: takes element pairs, forms products and keeps the running sums
`default_nettype none
module vpcs_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [vpcs_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [vpcs_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                          last_elem,
    input  wire logic                          q_full,
    output logic                               push,
    output vpcs_pkg::vpcs_entry_t              push_entry
);
    import vpcs_pkg::*;

    logic signed [SUM_W-1:0]  dot_reg, norm_a_reg, norm_b_reg;
    logic signed [SUM_W-1:0]  dot_next, norm_a_next, norm_b_next;
    logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        p_ab = PROD_W'(elem_a) * PROD_W'(elem_b);
        p_aa = PROD_W'(elem_a) * PROD_W'(elem_a);
        p_bb = PROD_W'(elem_b) * PROD_W'(elem_b);
        dot_next    = sat_add(dot_reg, p_ab);
        norm_a_next = sat_add(norm_a_reg, p_aa);
        norm_b_next = sat_add(norm_b_reg, p_bb);
        push_entry.product = p_ab;
        push_entry.last    = last_elem;
        push_entry.dot     = dot_next;
        push_entry.norm_a  = norm_a_next;
        push_entry.norm_b  = norm_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
        end
        else if (push)
        begin
            dot_reg    <= last_elem ? '0 : dot_next;
            norm_a_reg <= last_elem ? '0 : norm_a_next;
            norm_b_reg <= last_elem ? '0 : norm_b_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/vpcs_queue.sv
// short queue between front and back end
`default_nettype none
module vpcs_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire vpcs_pkg::vpcs_entry_t push_entry,
    input  wire logic                  pop,
    output vpcs_pkg::vpcs_entry_t      head,
    output logic                       empty,
    output logic                       full
);
    import vpcs_pkg::*;

    vpcs_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/vpcs_back.sv
// back end: square roots, denominator and divide, output register
`default_nettype none
module vpcs_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire vpcs_pkg::vpcs_entry_t        head,
    input  wire logic                         empty,
    output logic                              pop,
    input  wire logic [vpcs_pkg::CFG_W-1:0]   min_denominator,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [vpcs_pkg::PROD_W-1:0] product,
    output logic signed [vpcs_pkg::SIM_W-1:0]  similarity,
    output logic                              similarity_valid,
    output logic                              last_out
);
    import vpcs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_MUL, S_CHK, S_DIV, S_DONE} state_t;

    state_t              state_reg;
    logic [4:0]          cnt_reg;
    logic [SUM_W-1:0]    na_reg, nb_reg, ra_reg, rb_reg, bit_reg;
    logic [SUM_W-1:0]    na_next, nb_next, ra_next, rb_next;
    logic [SUM_W-1:0]    mag_reg, d_reg;
    logic                neg_reg;
    logic [NUM_W-1:0]    rem_reg, dv_reg, num;
    logic [QUOT_W-1:0]   q_reg, q_sat;
    logic                out_free;

    assign out_free  = !out_valid || !out_stall;
    assign num       = (NUM_W'(mag_reg) << FRAC_BITS) + NUM_W'(d_reg >> 1);
    assign q_sat     = (q_reg > SIM_ONE) ? SIM_ONE : q_reg;

    always_comb
    begin
        na_next = na_reg;
        ra_next = ra_reg >> 1;
        if (na_reg >= ra_reg + bit_reg)
        begin
            na_next = na_reg - (ra_reg + bit_reg);
            ra_next = (ra_reg >> 1) + bit_reg;
        end
        nb_next = nb_reg;
        rb_next = rb_reg >> 1;
        if (nb_reg >= rb_reg + bit_reg)
        begin
            nb_next = nb_reg - (rb_reg + bit_reg);
            rb_next = (rb_reg >> 1) + bit_reg;
        end
    end

    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            S_IDLE:  pop = !empty && !head.last && out_free;
            S_DONE:  pop = out_free;
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid        <= 1'b0;
            cnt_reg          <= '0;
            na_reg           <= '0;
            nb_reg           <= '0;
            ra_reg           <= '0;
            rb_reg           <= '0;
            bit_reg          <= '0;
            mag_reg          <= '0;
            d_reg            <= '0;
            neg_reg          <= 1'b0;
            rem_reg          <= '0;
            dv_reg           <= '0;
            q_reg            <= '0;
            product          <= '0;
            similarity       <= '0;
            similarity_valid <= 1'b0;
            last_out         <= 1'b0;
        end
        else
        begin
            if (pop)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty && !head.last && out_free)
                    begin
                        product          <= head.product;
                        similarity       <= '0;
                        similarity_valid <= 1'b0;
                        last_out         <= 1'b0;
                    end
                    else if (!empty && head.last)
                    begin
                        na_reg    <= head.norm_a[SUM_W-1] ? '0 : head.norm_a;
                        nb_reg    <= head.norm_b[SUM_W-1] ? '0 : head.norm_b;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                        bit_reg   <= SUM_W'(1) << (SUM_W - 2);
                        neg_reg   <= head.dot[SUM_W-1];
                        mag_reg   <= head.dot[SUM_W-1] ? SUM_W'(-head.dot) : head.dot;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                    ra_reg  <= ra_next;
                    rb_reg  <= rb_next;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(ROOT_W - 1))
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    d_reg     <= ra_reg[ROOT_W-1:0] * rb_reg[ROOT_W-1:0];
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (d_reg == '0 || d_reg < SUM_W'(min_denominator))
                    begin
                        q_reg     <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (num >= (NUM_W'(d_reg) << QUOT_W))
                    begin
                        q_reg     <= SIM_ONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rem_reg   <= num;
                        dv_reg    <= NUM_W'(d_reg) << (QUOT_W - 1);
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_reg >= dv_reg)
                    begin
                        rem_reg <= rem_reg - dv_reg;
                        q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
                    end
                    else
                        q_reg   <= {q_reg[QUOT_W-2:0], 1'b0};
                    dv_reg  <= dv_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(QUOT_W - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        product          <= head.product;
                        similarity       <= neg_reg ? -SIM_W'(q_sat) : SIM_W'(q_sat);
                        similarity_valid <= 1'b1;
                        last_out         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/vector_product_cosine_similarity_tb.sv
// testbench for the streaming cosine similarity block: directed and random vectors, floor settings, backpressure
`timescale 1ns / 1ps
module vector_product_cosine_similarity_tb;

    import vpcs_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [ELEM_W-1:0] elem_a = '0;
    logic signed [ELEM_W-1:0] elem_b = '0;
    logic last_elem = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PROD_W-1:0] product;
    logic signed [SIM_W-1:0] similarity;
    logic similarity_valid;
    logic last_out;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic signed [SIM_W-1:0]  similarity;
        logic                     sim_valid;
        logic                     last;
    } beat_t;

    beat_t expected_beats[$];
    logic signed [SUM_W-1:0] dot_acc, norm_a_acc, norm_b_acc;
    logic [CFG_W-1:0] denom_floor;
    int mismatches = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_rx = 1'b0;
    int hold_len = 0;

    vector_product_cosine_similarity dut (.*);

    always #4 clk = ~clk;

    function automatic logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] s,
                                                          logic signed [63:0] x);
        logic signed [63:0] r;
        r = 64'(s) + x;
        if (r > 64'sh7FFF_FFFF_FFFF) return {1'b0, {(SUM_W-1){1'b1}}};
        if (r < -64'sh8000_0000_0000) return {1'b1, {(SUM_W-1){1'b0}}};
        return r[SUM_W-1:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 48;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [SIM_W-1:0] cosine_of_sums();
        logic [63:0] na, nb, d, mag, q;
        na = norm_a_acc < 0 ? 64'd0 : 64'(norm_a_acc);
        nb = norm_b_acc < 0 ? 64'd0 : 64'(norm_b_acc);
        d = floor_root(na) * floor_root(nb);
        if (d == 0 || d < 64'(denom_floor)) return '0;
        mag = dot_acc < 0 ? 64'(-64'(dot_acc)) : 64'(dot_acc);
        q = ((mag << 14) + (d >> 1)) / d;
        if (q > 64'd16384) q = 64'd16384;
        return dot_acc < 0 ? SIM_W'(-q) : SIM_W'(q);
    endfunction

    function automatic void predict_pair(logic signed [ELEM_W-1:0] a,
                                         logic signed [ELEM_W-1:0] b, logic lst);
        beat_t e;
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        dot_acc = clamp_add(dot_acc, p);
        norm_a_acc = clamp_add(norm_a_acc, 64'(a) * 64'(a));
        norm_b_acc = clamp_add(norm_b_acc, 64'(b) * 64'(b));
        e.product = p[PROD_W-1:0];
        e.similarity = '0;
        e.sim_valid = lst;
        e.last = lst;
        if (lst)
        begin
            e.similarity = cosine_of_sums();
            dot_acc = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
        end
        expected_beats = {expected_beats, e};
    endfunction

    task automatic send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                             logic lst);
        while (!no_idle && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last_elem <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pair(a, b, lst);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_floor(logic [CFG_W-1:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_MIN_DENOM);
        pwdata <= 32'(v);
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        denom_floor = v;
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return ELEM_W'($urandom_range(15));
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_pair(rand_elem(), rand_elem(), i == len - 1);
    endtask

    task automatic test_directed();
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh1000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh1000, 16'sh1000, 1'b0);
        send_pair(16'sh0000, 16'shF000, 1'b1);
        send_pair(16'sh0003, 16'sh0005, 1'b0);
        send_pair(16'sh0004, 16'sh0001, 1'b1);
        send_pair(16'sh0001, 16'shFFFF, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);
        send_pair(16'sh0001, 16'sh0001, 1'b1);
    endtask

    task automatic test_floor_settings();
        drain();
        write_floor(16'hFFFF);
        send_pair(16'sh00FF, 16'sh00FF, 1'b1);
        send_pair(16'sh0100, 16'sh0100, 1'b1);
        send_pair(16'sh0101, 16'sh00FF, 1'b1);
        send_vector(8);
        drain();
        write_floor(16'h0000);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0001, 16'sh0002, 1'b1);
        send_vector(5);
        drain();
        write_floor(16'h0400);
        send_pair(16'sh0020, 16'sh001F, 1'b1);
        send_pair(16'sh0021, 16'sh0020, 1'b1);
        send_vector(6);
    endtask

    task automatic test_random_vectors(int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(12, 1);
            if (sent > total / 2 && sent < total / 2 + 300) no_idle = 1'b1;
            else no_idle = 1'b0;
            send_vector(len);
            sent += len;
            if ($urandom_range(30) == 0)
            begin
                drain();
                write_floor(16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        drain();
        write_floor(16'd1);
        hold_len = 300;
        hold_rx = 1'b1;
        send_vector(20);
    endtask

    always @(posedge clk)
    begin
        if (hold_rx)
        begin
            out_stall <= 1'b1;
            if (hold_len == 0) hold_rx <= 1'b0;
            else hold_len <= hold_len - 1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat product=%0d", product);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (product !== e.product || similarity !== e.similarity
                    || similarity_valid !== e.sim_valid || last_out !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp p=%0d s=%0d v=%0b l=%0b",
                                 e.product, e.similarity, e.sim_valid, e.last,
                                 " got p=%0d s=%0d v=%0b l=%0b",
                                 product, similarity, similarity_valid, last_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        dot_acc = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        denom_floor = 16'd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_floor_settings();
        test_backpressure();
        test_random_vectors(1750);
        drain();
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
